>>> hdl/mfh_pkg.sv
// shared types, command codes and stream field layout for the focus history block
`timescale 1ns / 1ps
`default_nettype none

package mfh_pkg;

  // default sizing
  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF    = 32;

  // fixed field widths of the stream ports
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned WID_W   = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;

  // input tdata layout: win_id, position
  localparam int unsigned IN_WID_LSB  = 0;
  localparam int unsigned IN_POS_LSB  = IN_WID_LSB + WID_W;
  localparam int unsigned IN_USED_W   = IN_POS_LSB + POS_W;
  localparam int unsigned IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout: foreground_id, history_count, entry_id, open_count
  localparam int unsigned OUT_FG_LSB    = 0;
  localparam int unsigned OUT_HIST_LSB  = OUT_FG_LSB + WID_W;
  localparam int unsigned OUT_ENTRY_LSB = OUT_HIST_LSB + COUNT_W;
  localparam int unsigned OUT_OPEN_LSB  = OUT_ENTRY_LSB + WID_W;
  localparam int unsigned OUT_USED_W    = OUT_OPEN_LSB + COUNT_W;
  localparam int unsigned OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  // request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_PRUNE = 3'd2,
    CMD_FOCUS = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // one request as taken from the input stream
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [WID_W-1:0] win_id;
    logic [POS_W-1:0] position;
  } item_t;

  // one result as handed to the output stream
  typedef struct packed {
    logic [WID_W-1:0]   foreground_id;
    logic [COUNT_W-1:0] history_count;
    logic [WID_W-1:0]   entry_id;
    logic [COUNT_W-1:0] open_count;
  } result_t;

  // handshake control from the stream side to the sequencer
  typedef struct packed {
    logic start;
    logic out_free;
  } seq_ctrl_t;

  // sequencer status towards the stream side
  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

`default_nettype wire

>>> hdl/mfh_cmp.sv
// shared id comparator used by every list and open set walk
`timescale 1ns / 1ps
`default_nettype none

module mfh_cmp #(
  parameter int unsigned ID_BITS = mfh_pkg::ID_BITS_DEF
) (
  input  wire logic [ID_BITS-1:0] a_i,
  input  wire logic [ID_BITS-1:0] b_i,
  output logic                    eq_o,
  output logic                    a_zero_o
);

  // equality of the two operands and zero test of the first
  assign eq_o     = (a_i == b_i);
  assign a_zero_o = (a_i == '0);

endmodule

`default_nettype wire

>>> hdl/mfh_seq.sv
// sequencer with recency list and open set memories, walking them through one comparator
`timescale 1ns / 1ps
`default_nettype none

module mfh_seq #(
  parameter int unsigned LIST_DEPTH = mfh_pkg::LIST_DEPTH_DEF,
  parameter int unsigned ID_BITS    = mfh_pkg::ID_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mfh_pkg::seq_ctrl_t ctrl_i,
  input  wire mfh_pkg::item_t     item_i,
  output mfh_pkg::seq_stat_t      stat_o,
  output mfh_pkg::result_t        res_o
);

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned PW = (CW > mfh_pkg::POS_W) ? CW : mfh_pkg::POS_W;

  typedef enum logic [14:0] {
    ST_IDLE      = 15'h0001,
    ST_DECODE    = 15'h0002,
    ST_OPEN_RD   = 15'h0004,
    ST_OPEN_CMP  = 15'h0008,
    ST_DROP_RD   = 15'h0010,
    ST_DROP_GET  = 15'h0020,
    ST_SHIFT_RD  = 15'h0040,
    ST_SHIFT_WR  = 15'h0080,
    ST_PRUNE_RD  = 15'h0100,
    ST_PRUNE_GET = 15'h0200,
    ST_DUP_RD    = 15'h0400,
    ST_DUP_CMP   = 15'h0800,
    ST_READ_RD   = 15'h1000,
    ST_READ_GET  = 15'h2000,
    ST_DONE      = 15'h4000
  } state_e;

  state_e                       state_q, state_d;
  mfh_pkg::cmd_e                cmd_q, cmd_d;
  logic [ID_BITS-1:0]           id_q, id_d;
  logic [mfh_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [ID_BITS-1:0]           cand_q, cand_d;
  logic [ID_BITS-1:0]           fg_q, fg_d;
  logic [ID_BITS-1:0]           entry_q, entry_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [CW-1:0]                open_total_q, open_total_d;
  logic [CW-1:0]                rd_q, rd_d;
  logic [CW-1:0]                wr_q, wr_d;
  logic [CW-1:0]                k_q, k_d;
  logic                         push_q, push_d;

  // memory ports
  logic [ID_BITS-1:0] list_mem [LIST_DEPTH];
  logic [ID_BITS-1:0] open_mem [LIST_DEPTH];
  logic               list_we;
  logic [AW-1:0]      list_waddr;
  logic [ID_BITS-1:0] list_wdata;
  logic [AW-1:0]      list_raddr;
  logic [ID_BITS-1:0] list_rdata_q;
  logic               open_we;
  logic [AW-1:0]      open_waddr;
  logic [AW-1:0]      open_raddr;
  logic [ID_BITS-1:0] open_rdata_q;

  // shared comparator
  logic [ID_BITS-1:0] cmp_a;
  logic [ID_BITS-1:0] cmp_b;
  logic               cmp_eq;
  logic               cmp_a_zero;

  assign cmp_a = (state_q == ST_OPEN_CMP) ? open_rdata_q : list_rdata_q;
  assign cmp_b = (state_q == ST_PRUNE_GET) ? fg_q : cand_q;

  mfh_cmp #(
    .ID_BITS (ID_BITS)
  ) u_cmp (
    .a_i      (cmp_a),
    .b_i      (cmp_b),
    .eq_o     (cmp_eq),
    .a_zero_o (cmp_a_zero)
  );

  // recency list memory
  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_rdata_q <= list_mem[list_raddr];
  end

  // open set memory
  always_ff @(posedge clk_i) begin
    if (open_we) begin
      open_mem[open_waddr] <= id_q;
    end
    open_rdata_q <= open_mem[open_raddr];
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    id_d         = id_q;
    pos_d        = pos_q;
    cand_d       = cand_q;
    fg_d         = fg_q;
    entry_d      = entry_q;
    cnt_d        = cnt_q;
    open_total_d = open_total_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    k_d          = k_q;
    push_d       = push_q;
    list_we      = 1'b0;
    list_waddr   = wr_q[AW-1:0];
    list_wdata   = list_rdata_q;
    list_raddr   = rd_q[AW-1:0];
    open_we      = 1'b0;
    open_waddr   = open_total_q[AW-1:0];
    open_raddr   = k_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (ctrl_i.start) begin
          cmd_d   = mfh_pkg::cmd_e'(item_i.command);
          id_d    = ID_BITS'(item_i.win_id);
          pos_d   = item_i.position;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        entry_d = '0;
        rd_d    = '0;
        wr_d    = '0;
        k_d     = '0;
        unique case (cmd_q)
          mfh_pkg::CMD_CLEAR: begin
            open_total_d = '0;
            state_d      = ST_DONE;
          end
          mfh_pkg::CMD_ADD: begin
            if ((id_q != '0) && (open_total_q < CW'(LIST_DEPTH))) begin
              open_we      = 1'b1;
              open_total_d = open_total_q + CW'(1);
            end
            state_d = ST_DONE;
          end
          mfh_pkg::CMD_PRUNE: begin
            state_d = ST_PRUNE_RD;
          end
          mfh_pkg::CMD_FOCUS: begin
            if ((fg_q != id_q) && (fg_q != '0)) begin
              cand_d  = fg_q;
              push_d  = 1'b1;
              state_d = ST_OPEN_RD;
            end else begin
              fg_d    = id_q;
              state_d = ST_PRUNE_RD;
            end
          end
          mfh_pkg::CMD_READ: begin
            state_d = ST_READ_RD;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      // walk the open set looking for the candidate
      ST_OPEN_RD: begin
        if (k_q >= open_total_q) begin
          if (push_q) begin
            fg_d    = id_q;
            rd_d    = '0;
            wr_d    = '0;
            state_d = ST_PRUNE_RD;
          end else begin
            rd_d    = rd_q + CW'(1);
            state_d = ST_PRUNE_RD;
          end
        end else begin
          state_d = ST_OPEN_CMP;
        end
      end

      ST_OPEN_CMP: begin
        if (cmp_eq) begin
          k_d = '0;
          if (push_q) begin
            rd_d    = '0;
            wr_d    = '0;
            state_d = ST_DROP_RD;
          end else begin
            state_d = ST_DUP_RD;
          end
        end else begin
          k_d     = k_q + CW'(1);
          state_d = ST_OPEN_RD;
        end
      end

      // remove the previous foreground from the list before it goes to the front
      ST_DROP_RD: begin
        if (rd_q >= cnt_q) begin
          if (wr_q >= CW'(LIST_DEPTH)) begin
            k_d = CW'(LIST_DEPTH - 1);
          end else begin
            k_d = wr_q;
          end
          state_d = ST_SHIFT_RD;
        end else begin
          state_d = ST_DROP_GET;
        end
      end

      ST_DROP_GET: begin
        if (!cmp_eq) begin
          list_we = 1'b1;
          wr_d    = wr_q + CW'(1);
        end
        rd_d    = rd_q + CW'(1);
        state_d = ST_DROP_RD;
      end

      // move entries one place back, oldest falls off when full
      ST_SHIFT_RD: begin
        list_raddr = AW'(k_q - CW'(1));
        if (k_q == '0) begin
          list_we    = 1'b1;
          list_waddr = '0;
          list_wdata = cand_q;
          cnt_d      = wr_q + CW'(1);
          if (wr_q >= CW'(LIST_DEPTH)) begin
            cnt_d = CW'(LIST_DEPTH);
          end
          fg_d       = id_q;
          rd_d       = '0;
          wr_d       = '0;
          state_d    = ST_PRUNE_RD;
        end else begin
          state_d = ST_SHIFT_WR;
        end
      end

      ST_SHIFT_WR: begin
        list_we    = 1'b1;
        list_waddr = k_q[AW-1:0];
        k_d        = k_q - CW'(1);
        state_d    = ST_SHIFT_RD;
      end

      // prune: drop zeros, the foreground, closed ids and repeats
      ST_PRUNE_RD: begin
        if (rd_q >= cnt_q) begin
          cnt_d   = wr_q;
          state_d = ST_DONE;
        end else begin
          state_d = ST_PRUNE_GET;
        end
      end

      ST_PRUNE_GET: begin
        cand_d = list_rdata_q;
        if (cmp_a_zero || cmp_eq) begin
          rd_d    = rd_q + CW'(1);
          state_d = ST_PRUNE_RD;
        end else begin
          k_d     = '0;
          push_d  = 1'b0;
          state_d = ST_OPEN_RD;
        end
      end

      // look for the candidate among the entries already kept
      ST_DUP_RD: begin
        list_raddr = k_q[AW-1:0];
        if (k_q >= wr_q) begin
          list_we    = 1'b1;
          list_wdata = cand_q;
          wr_d       = wr_q + CW'(1);
          rd_d       = rd_q + CW'(1);
          state_d    = ST_PRUNE_RD;
        end else begin
          state_d = ST_DUP_CMP;
        end
      end

      ST_DUP_CMP: begin
        if (cmp_eq) begin
          rd_d    = rd_q + CW'(1);
          state_d = ST_PRUNE_RD;
        end else begin
          k_d     = k_q + CW'(1);
          state_d = ST_DUP_RD;
        end
      end

      // single entry read
      ST_READ_RD: begin
        list_raddr = AW'(pos_q);
        state_d    = ST_READ_GET;
      end

      ST_READ_GET: begin
        if (PW'(pos_q) < PW'(cnt_q)) begin
          entry_d = list_rdata_q;
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (ctrl_i.out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= mfh_pkg::CMD_CLEAR;
      id_q         <= '0;
      pos_q        <= '0;
      cand_q       <= '0;
      fg_q         <= '0;
      entry_q      <= '0;
      cnt_q        <= '0;
      open_total_q <= '0;
      rd_q         <= '0;
      wr_q         <= '0;
      k_q          <= '0;
      push_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      id_q         <= id_d;
      pos_q        <= pos_d;
      cand_q       <= cand_d;
      fg_q         <= fg_d;
      entry_q      <= entry_d;
      cnt_q        <= cnt_d;
      open_total_q <= open_total_d;
      rd_q         <= rd_d;
      wr_q         <= wr_d;
      k_q          <= k_d;
      push_q       <= push_d;
    end
  end

  // status and result
  assign stat_o.idle = (state_q == ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);

  assign res_o.foreground_id = mfh_pkg::WID_W'(fg_q);
  assign res_o.history_count = mfh_pkg::COUNT_W'(cnt_q);
  assign res_o.entry_id      = mfh_pkg::WID_W'(entry_q);
  assign res_o.open_count    = mfh_pkg::COUNT_W'(open_total_q);

endmodule

`default_nettype wire

>>> hdl/mru_focus_history_top.sv
// top level of the focus history block: stream ports, output register, sequencer
//
// channel   | direction | data                                        | side info
// ----------+-----------+---------------------------------------------+----------------
// s_axis    | in        | win_id[31:0], position[35:32]               | tuser: command
// m_axis    | out       | foreground_id, history_count, entry_id,     | none
//           |           | open_count                                  |
//
// clear, add and undefined commands finish in the decode state; a read adds a read and a get state
// a prune walks the list through one comparator and one read port per memory:
//   each entry that is not zero or the foreground is looked up in the open set and then among the kept entries;
//   a focus change adds an open set scan and, if the old foreground is open, a drop
//   and a shift pass before its prune
// s_axis_tready is high only while the sequencer is idle; a result may wait in the
//   output register while the next request is taken
// reset clears the list count, open count and foreground; no memory clearing pass
`timescale 1ns / 1ps
`default_nettype none

module mru_focus_history_top #(
  parameter int unsigned LIST_DEPTH = mfh_pkg::LIST_DEPTH_DEF,
  parameter int unsigned ID_BITS    = mfh_pkg::ID_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // win_id [31:0], position [35:32], zero fill above
  input  wire logic [mfh_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // command [2:0]
  input  wire logic [mfh_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // foreground_id [31:0], history_count [36:32], entry_id [68:37],
  // open_count [73:69], zero fill above
  output logic [mfh_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  mfh_pkg::seq_ctrl_t ctrl;
  mfh_pkg::seq_stat_t stat;
  mfh_pkg::item_t     item;
  mfh_pkg::result_t   res;

  logic                               out_valid_q, out_valid_d;
  logic [mfh_pkg::OUT_TDATA_W-1:0]    out_data_q, out_data_d;

  // request unpacking
  assign item.command   = s_axis_tuser;
  assign item.win_id    = s_axis_tdata[mfh_pkg::IN_WID_LSB +: mfh_pkg::WID_W];
  assign item.position  = s_axis_tdata[mfh_pkg::IN_POS_LSB +: mfh_pkg::POS_W];

  assign s_axis_tready  = stat.idle;
  assign ctrl.start     = s_axis_tvalid && stat.idle;
  assign ctrl.out_free  = !out_valid_q || m_axis_tready;

  mfh_seq #(
    .LIST_DEPTH (LIST_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .item_i (item),
    .stat_o (stat),
    .res_o  (res)
  );

  // output register loading
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (stat.done && ctrl.out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      out_data_d[mfh_pkg::OUT_FG_LSB    +: mfh_pkg::WID_W]   = res.foreground_id;
      out_data_d[mfh_pkg::OUT_HIST_LSB  +: mfh_pkg::COUNT_W] = res.history_count;
      out_data_d[mfh_pkg::OUT_ENTRY_LSB +: mfh_pkg::WID_W]   = res.entry_id;
      out_data_d[mfh_pkg::OUT_OPEN_LSB  +: mfh_pkg::COUNT_W] = res.open_count;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> hdl/mfh_checker.sv
// port level checks for the focus history block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module mfh_checker #(
  parameter int unsigned LIST_DEPTH = mfh_pkg::LIST_DEPTH_DEF
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [mfh_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // one request at a time: a taken request closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still open after a request was taken");

  // a stalled result keeps its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // list count never beyond the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((LIST_DEPTH > 31) ||
      (m_axis_tdata[mfh_pkg::OUT_HIST_LSB +: mfh_pkg::COUNT_W] <= LIST_DEPTH)))
    else $error("history count beyond list depth");

  // open count never beyond the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((LIST_DEPTH > 31) ||
      (m_axis_tdata[mfh_pkg::OUT_OPEN_LSB +: mfh_pkg::COUNT_W] <= LIST_DEPTH)))
    else $error("open count beyond list depth");

  // zero fill of the result stays clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[mfh_pkg::OUT_TDATA_W-1:mfh_pkg::OUT_USED_W] == '0))
    else $error("result fill bits set");

endmodule

bind mru_focus_history_top mfh_checker #(
  .LIST_DEPTH (LIST_DEPTH)
) u_mfh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> tb/sv/tb_mru_focus_history_top.sv
// self-checking bench for the focus history block: directed, full-list, stall and random phases
`timescale 1ns / 1ps

module tb_mru_focus_history_top;
  import mfh_pkg::*;

  localparam int unsigned DEPTH       = LIST_DEPTH_DEF;
  localparam int unsigned POOL_N      = 20;
  localparam int unsigned ITEM_TARGET = 1150;
  localparam int unsigned LIMIT       = 8_000_000;
  localparam int unsigned TAIL_CYCLES = 64;

  // command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]       s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // predicted state of the block
  logic [WID_W-1:0] hist_ids [DEPTH];
  int unsigned      hist_len;
  logic [WID_W-1:0] fg_now;
  logic [WID_W-1:0] open_ids [DEPTH];
  int unsigned      open_len;

  result_t          pending_results [$];
  logic [WID_W-1:0] id_pool [POOL_N];
  int unsigned      requests_sent = 0;
  int unsigned      error_count   = 0;
  int unsigned      cycle_count   = 0;
  int               hold_left     = 0;
  bit               gaps_on       = 1'b0;

  mru_focus_history_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_open_id(logic [WID_W-1:0] id);
    int unsigned i;
    if (id == '0) return 1'b0;
    for (i = 0; i < open_len; i++) begin
      if (open_ids[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  // remove every copy of id, keeping the order of the rest
  function automatic void drop_from_history(logic [WID_W-1:0] id);
    int unsigned rd;
    int unsigned wr;
    wr = 0;
    if (id == '0) return;
    for (rd = 0; rd < hist_len; rd++) begin
      if (hist_ids[rd] != id) begin
        hist_ids[wr] = hist_ids[rd];
        wr++;
      end
    end
    for (rd = wr; rd < DEPTH; rd++) hist_ids[rd] = '0;
    hist_len = wr;
  endfunction

  // move an open id to the front, losing the oldest entry when full
  function automatic void push_to_front(logic [WID_W-1:0] id);
    int unsigned n;
    int unsigned i;
    if (id == '0 || !is_open_id(id)) return;
    drop_from_history(id);
    n = (hist_len >= DEPTH) ? DEPTH - 1 : hist_len;
    for (i = n; i > 0; i--) hist_ids[i] = hist_ids[i-1];
    hist_ids[0] = id;
    hist_len = n + 1;
  endfunction

  // keep first copies of open ids other than zero and the foreground
  function automatic void prune_history();
    int unsigned      rd;
    int unsigned      wr;
    int unsigned      k;
    logic [WID_W-1:0] id;
    bit               seen;
    wr = 0;
    for (rd = 0; rd < hist_len; rd++) begin
      id = hist_ids[rd];
      if (id != '0 && id != fg_now && is_open_id(id)) begin
        seen = 1'b0;
        for (k = 0; k < wr; k++) begin
          if (hist_ids[k] == id) seen = 1'b1;
        end
        if (!seen) begin
          hist_ids[wr] = id;
          wr++;
        end
      end
    end
    for (rd = wr; rd < DEPTH; rd++) hist_ids[rd] = '0;
    hist_len = wr;
  endfunction

  // apply one request and return the result it should produce
  function automatic result_t advance_history(logic [CMD_W-1:0] cmd, logic [WID_W-1:0] id,
                                              logic [POS_W-1:0] pos);
    result_t res;
    res = '0;
    case (cmd)
      CMD_CLEAR: open_len = 0;
      CMD_ADD: begin
        if (id != '0 && open_len < DEPTH) begin
          open_ids[open_len] = id;
          open_len++;
        end
      end
      CMD_PRUNE: prune_history();
      CMD_FOCUS: begin
        if (fg_now != id) push_to_front(fg_now);
        fg_now = id;
        drop_from_history(id);
        prune_history();
      end
      CMD_READ: begin
        if (pos < hist_len) res.entry_id = hist_ids[pos];
      end
      default: ;
    endcase
    res.foreground_id = fg_now;
    res.history_count = COUNT_W'(hist_len);
    res.open_count    = COUNT_W'(open_len);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short idle stretches, now and then a long one
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  function automatic logic [WID_W-1:0] fresh_id();
    logic [WID_W-1:0] v;
    do v = $urandom; while (v == '0);
    return v;
  endfunction

  // mostly ids from the shared pool so that repeats and matches happen
  function automatic logic [WID_W-1:0] pick_window_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return id_pool[$urandom_range(0, POOL_N - 1)];
    if (r < 94) return '0;
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] any_pos();
    return POS_W'($urandom_range(0, DEPTH - 1));
  endfunction

  // offer one request and wait for it to be taken; call at a rising edge
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [WID_W-1:0] id,
                              input logic [POS_W-1:0] pos);
    int                    gap;
    logic [IN_TDATA_W-1:0] word;
    gap = (gaps_on && $urandom_range(0, 99) < 40) ? idle_length() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word = '0;
    word[IN_WID_LSB +: WID_W] = id;
    word[IN_POS_LSB +: POS_W] = pos;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pending_results.push_back(advance_history(cmd, id, pos));
    requests_sent++;
  endtask

  // any command, well formed or not
  task automatic send_random_request();
    logic [CMD_W-1:0] cmd;
    cmd = CMD_W'($urandom_range(CMD_CLEAR, CMD_SPARE_HI));
    send_request(cmd, ($urandom_range(0, 3) == 0) ? $urandom : pick_window_id(), any_pos());
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes of the fields and each special case
  task automatic test_edge_cases();
    gaps_on = 1'b0;
    send_request(CMD_READ,  '0,            '0);          // empty list after reset
    send_request(CMD_READ,  '1,            '1);          // read past count
    send_request(CMD_ADD,   '0,            '0);          // zero id ignored
    send_request(CMD_ADD,   '1,            '1);
    send_request(CMD_ADD,   32'h0000_0001, '0);
    send_request(CMD_ADD,   32'hA5A5_5A5A, 4'h5);
    send_request(CMD_ADD,   32'h0000_0001, 4'hA);        // duplicate open id stored again
    send_request(CMD_FOCUS, '1,            '0);          // previous foreground zero
    send_request(CMD_FOCUS, '1,            '0);          // same id again
    send_request(CMD_FOCUS, 32'h0000_0001, '0);
    send_request(CMD_FOCUS, 32'h5A5A_A5A5, '0);          // new foreground not open
    send_request(CMD_READ,  '1,            '0);
    send_request(CMD_READ,  '0,            4'h1);
    send_request(CMD_READ,  '0,            '1);
    send_request(CMD_FOCUS, 32'hA5A5_5A5A, '1);          // previous foreground closed
    send_request(CMD_FOCUS, '0,            '0);          // focus to none
    send_request(CMD_SPARE_LO,  '1, '1);
    send_request(CMD_SPARE_MID, '0, '0);
    send_request(CMD_SPARE_HI,  '1, '1);
    send_request(CMD_CLEAR, '1,            '1);
    send_request(CMD_PRUNE, '0,            '0);          // nothing open, list empties
    send_request(CMD_ADD,   32'h8000_0000, '0);
    send_request(CMD_FOCUS, 32'h8000_0000, '0);
    send_request(CMD_FOCUS, 32'h7FFF_FFFF, '0);
    send_request(CMD_READ,  '1,            '0);
  endtask

  // fill the open set and the list, then make the push drop the oldest entry
  task automatic test_full_history();
    logic [WID_W-1:0] ids [DEPTH + 1];
    logic [WID_W-1:0] stray;
    logic [WID_W-1:0] late;
    int               round;
    int               i;
    for (round = 0; round < 3; round++) begin
      gaps_on = (round != 0);
      for (i = 0; i <= DEPTH; i++) ids[i] = fresh_id();
      stray = fresh_id();
      late  = fresh_id();
      send_request(CMD_CLEAR, $urandom, any_pos());
      for (i = 0; i < DEPTH; i++) send_request(CMD_ADD, ids[i], any_pos());
      // open set full, this one is ignored
      send_request(CMD_ADD, ids[DEPTH], any_pos());
      for (i = 0; i < DEPTH; i++) send_request(CMD_FOCUS, ids[i], any_pos());
      // closed foreground lets the list hold every open id
      send_request(CMD_FOCUS, stray, any_pos());
      for (i = 0; i < DEPTH; i++) send_request(CMD_READ, $urandom, POS_W'(i));
      send_request(CMD_CLEAR, $urandom, any_pos());
      for (i = 1; i < DEPTH; i++) send_request(CMD_ADD, ids[i], any_pos());
      send_request(CMD_ADD, stray, any_pos());
      // stray is now open and pushed onto a full list
      send_request(CMD_FOCUS, late, any_pos());
      send_request(CMD_READ, $urandom, '0);
      send_request(CMD_READ, $urandom, '1);
      send_request(CMD_PRUNE, $urandom, any_pos());
    end
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_output_backpressure();
    gaps_on   = 1'b0;
    hold_left = 600;
    repeat (24) send_random_request();
  endtask

  // sender waits for every result before going on
  task automatic test_sender_pause();
    int round;
    gaps_on = 1'b1;
    for (round = 0; round < 3; round++) begin
      repeat (6) send_random_request();
      wait_for_drain();
    end
  endtask

  // sessions of refreshes, focus runs and reads with random content, plus noise
  task automatic test_random_sessions();
    int kind;
    int n;
    while (requests_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 9) > 2);
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        // refresh of the open set
        send_request(CMD_CLEAR, $urandom, any_pos());
        n = $urandom_range(0, DEPTH + 2);
        repeat (n) send_request(CMD_ADD, pick_window_id(), any_pos());
        send_request(CMD_PRUNE, $urandom, any_pos());
      end else if (kind < 55) begin
        // run of focus changes with reads in between
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_request(CMD_FOCUS, pick_window_id(), any_pos());
          if ($urandom_range(0, 1) == 0) begin
            send_request(CMD_READ, $urandom,
                         POS_W'($urandom_range(0, (hist_len > 0) ? hist_len - 1 : 0)));
          end
        end
      end else if (kind < 72) begin
        n = $urandom_range(1, 5);
        repeat (n) send_request(CMD_READ, $urandom, any_pos());
      end else if (kind < 82) begin
        n = $urandom_range(1, 3);
        repeat (n) send_request(CMD_ADD, pick_window_id(), any_pos());
      end else if (kind < 90) begin
        send_request(($urandom_range(0, 1) == 0) ? CMD_PRUNE : CMD_CLEAR, $urandom, any_pos());
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_random_request();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver side and checking
  // ---------------------------------------------------------------------------

  // ready pattern: stretches of steady ready and stretches of random stalls
  initial begin : result_sink
    int stall_left;
    int stretch_left;
    bit choppy;
    stall_left   = 0;
    stretch_left = 0;
    choppy       = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stretch_left == 0) begin
        choppy       = ($urandom_range(0, 3) != 0);
        stretch_left = $urandom_range(20, 300);
      end else begin
        stretch_left--;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (choppy && $urandom_range(0, 99) < 30) stall_left = idle_length();
      end
    end
  end

  task automatic compare_field(input string name, input logic [WID_W-1:0] want,
                               input logic [WID_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // each accepted result against the oldest prediction
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result, expected none, got %h", $time, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        compare_field("foreground_id", want.foreground_id,
                      m_axis_tdata[OUT_FG_LSB +: WID_W]);
        compare_field("history_count", WID_W'(want.history_count),
                      WID_W'(m_axis_tdata[OUT_HIST_LSB +: COUNT_W]));
        compare_field("entry_id", want.entry_id,
                      m_axis_tdata[OUT_ENTRY_LSB +: WID_W]);
        compare_field("open_count", WID_W'(want.open_count),
                      WID_W'(m_axis_tdata[OUT_OPEN_LSB +: COUNT_W]));
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    int i;
    for (i = 0; i < DEPTH; i++) begin
      hist_ids[i] = '0;
      open_ids[i] = '0;
    end
    hist_len = 0;
    fg_now   = '0;
    open_len = 0;
    // id pool with both extremes of the id field
    id_pool[0] = '1;
    id_pool[1] = 32'h0000_0001;
    for (i = 2; i < POOL_N; i++) id_pool[i] = fresh_id();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_cases();
    wait_for_drain();
    test_full_history();
    wait_for_drain();
    test_output_backpressure();
    test_sender_pause();
    test_random_sessions();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/mfh_pkg.sv
hdl/mfh_cmp.sv
hdl/mfh_seq.sv
hdl/mru_focus_history_top.sv
hdl/mfh_checker.sv
tb/sv/tb_mru_focus_history_top.sv
